FILE: hw/rtl/spik_pkg.sv
// Shared types, constants and the CORDIC angle table for the polar IK pipeline.
// No dependencies.
package spik_pkg;

  localparam int RAD_W      = 46;  // radicand (2^30 - r^2) << 16
  localparam int ROOT_W     = 23;  // floor sqrt of the radicand
  localparam int SQRT_STEPS = 23;
  localparam int CORDIC_STEPS = 17;
  localparam int XY_W       = 28;  // signed CORDIC vector width
  localparam int Z_W        = 26;  // signed angle accumulator, degrees Q.16
  localparam int ANG_W      = 16;

  localparam logic [ANG_W-1:0] FULL_TURN_Q7 = 16'd46080;
  localparam logic [ANG_W-1:0] HALF_TURN_Q7 = 16'd23040;
  localparam logic [ANG_W-1:0] ALPHA_MAX_Q7 = 16'd11520;
  localparam logic [Z_W-1:0]   QUARTER_Q16  = 26'd5898240;
  localparam logic [23:0]      RAD_TO_DEG_K = 24'd15019745;
  localparam logic [15:0]      UNIT_REACH   = 16'd32768;

  typedef struct packed {
    logic [15:0] theta_angle;
    logic [15:0] reach_fraction;
  } in_t;

  typedef struct packed {
    logic [15:0] joint1_angle;
    logic [15:0] joint2_angle;
    logic        out_of_reach;
  } out_t;

  // side data that rides along the pipeline: flag, zero reach, theta in degrees
  typedef struct packed {
    logic             flag;
    logic             zero;
    logic [ANG_W-1:0] td;
  } side_t;

  function automatic logic [Z_W-1:0] atan_q16(input int idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      0:  v = 26'd2949120;
      1:  v = 26'd1740967;
      2:  v = 26'd919879;
      3:  v = 26'd466945;
      4:  v = 26'd234379;
      5:  v = 26'd117304;
      6:  v = 26'd58666;
      7:  v = 26'd29335;
      8:  v = 26'd14668;
      9:  v = 26'd7334;
      10: v = 26'd3667;
      11: v = 26'd1833;
      12: v = 26'd917;
      13: v = 26'd458;
      14: v = 26'd229;
      15: v = 26'd115;
      16: v = 26'd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/spik_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on spik_pkg.
module spik_sqrt #(
  parameter int TAG_W = 34
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [spik_pkg::RAD_W-1:0]  in_rad,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [spik_pkg::ROOT_W-1:0] out_root,
  output logic [TAG_W-1:0]            out_tag
);
  import spik_pkg::*;

  localparam int W = RAD_W + 1;

  logic [W-1:0]      v_r   [SQRT_STEPS];
  logic [W-1:0]      q_r   [SQRT_STEPS];
  logic [TAG_W-1:0]  tag_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_r;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (SQRT_STEPS - 1 - s));
    logic [W-1:0]     v_in, q_in, sum, v_nxt, q_nxt;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;

    if (s == 0) begin : g_first
      assign v_in   = W'(in_rad);
      assign q_in   = '0;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign q_in   = q_r[s-1];
      assign tag_in = tag_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    // take the bit when the remainder covers it
    always_comb begin
      sum = q_in + BIT;
      if (v_in >= sum) begin
        v_nxt = v_in - sum;
        q_nxt = (q_in >> 1) + BIT;
      end else begin
        v_nxt = v_in;
        q_nxt = q_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v_r[s]   <= v_nxt;
        q_r[s]   <= q_nxt;
        tag_r[s] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = q_r[SQRT_STEPS-1][ROOT_W-1:0];
  assign out_tag   = tag_r[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/spik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees Q.16.
// Depends on spik_pkg (angle table, widths).
module spik_cordic #(
  parameter int TAG_W = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [spik_pkg::XY_W-1:0]   in_x,
  input  logic [spik_pkg::XY_W-1:0]   in_y,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [spik_pkg::Z_W-1:0]    out_z,
  output logic [TAG_W-1:0]            out_tag
);
  import spik_pkg::*;

  logic signed [XY_W-1:0] x_r [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS];
  logic [TAG_W-1:0]       tag_r [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] vld_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic [Z_W-1:0] ATAN = atan_q16(i);
    logic signed [XY_W-1:0] x_in, y_in, dx, dy, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_in, z_nxt;
    logic [TAG_W-1:0]       tag_in;
    logic                   vld_in;

    if (i == 0) begin : g_first
      assign x_in   = in_x;
      assign y_in   = in_y;
      assign z_in   = '0;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign tag_in = tag_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    // rotate toward the x axis; arithmetic shift floors
    always_comb begin
      dx = y_in >>> i;
      dy = x_in >>> i;
      if (y_in > 0) begin
        x_nxt = x_in + dx;
        y_nxt = y_in - dy;
        z_nxt = z_in + signed'(ATAN);
      end else begin
        x_nxt = x_in - dx;
        y_nxt = y_in + dy;
        z_nxt = z_in - signed'(ATAN);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        z_r[i]   <= z_nxt;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign out_z     = z_r[CORDIC_STEPS-1];
  assign out_tag   = tag_r[CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/scara_polar_inverse_kinematics.sv
// Polar inverse kinematics of a two-link arm with equal links.
// Usage: present a target (theta Q3.13 rad, reach Q1.15) on in_valid/in_data;
// a beat is taken on a rising edge with in_valid high and in_stall low.
// Each beat yields exactly one result beat on out_valid/out_data holding
// joint1 = theta - acos(reach) and joint2 = theta + acos(reach), degrees Q9.7,
// each wrapped once into 0..360. Reach above one is saturated and flagged;
// zero reach gives 0 and 180 degrees.
// The pipeline has one prep stage (reach squared, theta to degrees),
// 23 square-root stages, 17 CORDIC stages and one output register.
// Throughput is one beat per clock while not stalled; the whole pipeline moves as one.
// When out_stall is high with a result waiting, every stage holds and
// in_stall rises in the same cycle, so nothing is dropped or repeated.
// Bubbles advance freely while the output register is empty.
// Synchronous active-low reset clears all valid bits; no result is pending
// after reset and no clearing pass is needed.
// Depends on spik_pkg, spik_sqrt and spik_cordic.
module scara_polar_inverse_kinematics (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  spik_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output spik_pkg::out_t  out_data
);
  import spik_pkg::*;

  localparam int SIDE_W = $bits(side_t);
  localparam int STAG_W = SIDE_W + 16;

  logic adv;

  // prep stage
  logic        pv_r;
  logic [15:0] pr_r;
  logic [31:0] pr2_r;
  side_t       pside_r;
  logic [15:0] r_sat;
  logic [39:0] tprod;

  // output stage
  logic  out_valid_r;
  out_t  out_r;
  out_t  out_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    r_sat = (in_data.reach_fraction > UNIT_REACH) ? UNIT_REACH : in_data.reach_fraction;
    tprod = 40'(in_data.theta_angle) * 40'(RAD_TO_DEG_K) + 40'(1 << 23);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r         <= r_sat;
      pr2_r        <= 32'(r_sat) * 32'(r_sat);
      pside_r.flag <= in_data.reach_fraction > UNIT_REACH;
      pside_r.zero <= in_data.reach_fraction == 16'd0;
      pside_r.td   <= tprod[39:24];
    end
  end

  // square root of (2^30 - r^2) << 16
  logic [RAD_W-1:0]  rad;
  logic              sv;
  logic [ROOT_W-1:0] root;
  logic [STAG_W-1:0] stag;

  assign rad = RAD_W'((32'(1 << 30) - pr2_r)) << 16;

  spik_sqrt #(.TAG_W(STAG_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pv_r),
    .in_rad    (rad),
    .in_tag    ({pr_r, pside_r}),
    .out_valid (sv),
    .out_root  (root),
    .out_tag   (stag)
  );

  logic             cv;
  logic [Z_W-1:0]   z;
  side_t            cside;
  logic [XY_W-1:0]  cx, cy;

  assign cx = XY_W'(stag[STAG_W-1:SIDE_W]) << 8;
  assign cy = XY_W'(root);

  spik_cordic #(.TAG_W(SIDE_W)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sv),
    .in_x      (cx),
    .in_y      (cy),
    .in_tag    (stag[SIDE_W-1:0]),
    .out_valid (cv),
    .out_z     (z),
    .out_tag   (cside)
  );

  // clamp, round to Q9.7, form both joints and wrap once; zero reach gives 0 and 180
  logic signed [Z_W-1:0] zc;
  logic [Z_W-1:0]        zr;
  logic [ANG_W-1:0]      alpha;
  logic signed [17:0]    j1, j2;

  always_comb begin
    zc = signed'(z);
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > signed'(QUARTER_Q16)) begin
      zc = signed'(QUARTER_Q16);
    end
    zr    = (Z_W'(zc) + Z_W'(256)) >> 9;
    alpha = (zr > Z_W'(ALPHA_MAX_Q7)) ? ALPHA_MAX_Q7 : zr[ANG_W-1:0];
    j1 = signed'(18'(cside.td)) - signed'(18'(alpha));
    j2 = signed'(18'(cside.td)) + signed'(18'(alpha));
    if (j1 < 0) begin
      j1 = j1 + signed'(18'(FULL_TURN_Q7));
    end
    if (j1 > signed'(18'(FULL_TURN_Q7))) begin
      j1 = j1 - signed'(18'(FULL_TURN_Q7));
    end
    if (j2 < 0) begin
      j2 = j2 + signed'(18'(FULL_TURN_Q7));
    end
    if (j2 > signed'(18'(FULL_TURN_Q7))) begin
      j2 = j2 - signed'(18'(FULL_TURN_Q7));
    end
    if (cside.zero) begin
      out_nxt.joint1_angle = '0;
      out_nxt.joint2_angle = HALF_TURN_Q7;
      out_nxt.out_of_reach = 1'b0;
    end else begin
      out_nxt.joint1_angle = j1[15:0];
      out_nxt.joint2_angle = j2[15:0];
      out_nxt.out_of_reach = cside.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_j1_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.joint1_angle <= FULL_TURN_Q7)
    else $error("joint1 out of range");

  a_j2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.joint2_angle <= FULL_TURN_Q7)
    else $error("joint2 out of range");

  a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && !adv) |=> pv_r)
    else $error("prep stage lost a beat while stalled");

  a_cordic_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cv && !adv) |=> cv)
    else $error("cordic stage lost a beat while stalled");

endmodule
